@@ rtl/swik_pkg.sv @@
// ----------------------------------------------------------------------------
// swik_pkg: shared types and constants for swerve inverse kinematics
// Word structs, register indexes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package swik_pkg;

  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  // Q12 components reach about 2^30; with CORDIC gain x/y stay below 2^31
  localparam int XyW = 32;
  localparam int ZW  = 34;

  localparam logic signed [ZW-1:0] PiQ30   = 34'sd3373259426;
  localparam logic [29:0]          KinvQ30 = 30'd652032874;
  localparam logic [29:0]          HalfSqrt2Q30 = 30'd759250125;

  typedef enum logic [2:0] {
    REG_TURN_RADIUS = 3'd0,
    REG_DRIVE_GAIN  = 3'd1,
    REG_FL_OFFSET   = 3'd2,
    REG_FR_OFFSET   = 3'd3,
    REG_BL_OFFSET   = 3'd4,
    REG_BR_OFFSET   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
  } in_word_t;

  typedef struct packed {
    logic        [15:0] fl_drive;
    logic        [15:0] fr_drive;
    logic        [15:0] bl_drive;
    logic        [15:0] br_drive;
    logic signed [15:0] fl_steer;
    logic signed [15:0] fr_steer;
    logic signed [15:0] bl_steer;
    logic signed [15:0] br_steer;
  } out_word_t;

  typedef struct packed {
    logic                  nz;
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cvec_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      default: r = 34'sd128;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/swerve_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics: four-wheel swerve drive inverse kinematics
// Chassis command to per-wheel drive speed and steer angle.
// ----------------------------------------------------------------------------
// Accepts one command word per cycle while in_stall is low. Two multiply
// stages form the rotation term, one stage builds the wheel vectors, one
// CORDIC micro-rotation per stage, then two multiply stages and a
// rounding/saturation stage. The whole pipe advances when the output
// register is empty or taken; in_stall follows out_stall while a result word
// waits.
module swerve_inverse_kinematics
  import swik_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int Lat = CordicSteps + 6;

  logic [14:0]        turn_radius_r;
  logic [11:0]        drive_gain_r;
  logic signed [15:0] offset_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_radius_r <= 15'd983;
      drive_gain_r  <= 12'd500;
      offset_r[0]   <= 16'sd5001;
      offset_r[1]   <= -16'sd14080;
      offset_r[2]   <= 16'sd3036;
      offset_r[3]   <= 16'sd5077;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TURN_RADIUS: turn_radius_r <= cfg_data[14:0];
        REG_DRIVE_GAIN:  drive_gain_r  <= cfg_data[11:0];
        REG_FL_OFFSET:   offset_r[0]   <= cfg_data;
        REG_FR_OFFSET:   offset_r[1]   <= cfg_data;
        REG_BL_OFFSET:   offset_r[2]   <= cfg_data;
        REG_BR_OFFSET:   offset_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline enable: all stages move together
  logic            en;
  logic [Lat-1:0]  vld_r;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Lat-2:0], in_valid};
  end

  // stage 1: yaw * radius
  logic signed [31:0] yr_r;
  logic signed [15:0] vx1_r, vy1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      yr_r  <= 32'(in_data.yaw_rate * $signed({1'b0, turn_radius_r}));
      vx1_r <= in_data.vel_x;
      vy1_r <= in_data.vel_y;
    end
  end

  // stage 2: w = round(yr * c / 2^30)
  logic signed [62:0] wp;
  logic signed [30:0] w_r;
  logic signed [15:0] vx2_r, vy2_r;
  assign wp = 63'(yr_r * $signed({1'b0, HalfSqrt2Q30})) + 63'sd536870912;
  always_ff @(posedge clk) begin
    if (en) begin
      w_r   <= 31'(wp >>> 30);
      vx2_r <= vx1_r;
      vy2_r <= vy1_r;
    end
  end

  // stage 3: wheel vectors with half-plane fold
  logic signed [XyW-1:0] vxq, vyq;
  cvec_t cin_r [4];
  assign vxq = XyW'(vx2_r) <<< 12;
  assign vyq = XyW'(vy2_r) <<< 12;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [XyW-1:0] px, py;
        px = (k < 2) ? vxq + XyW'(w_r) : vxq - XyW'(w_r);
        py = (k == 0 || k == 2) ? vyq + XyW'(w_r) : vyq - XyW'(w_r);
        cin_r[k].nz <= (px != '0) || (py != '0);
        if (px[XyW-1]) begin
          cin_r[k].x <= -px;
          cin_r[k].y <= -py;
          cin_r[k].z <= py[XyW-1] ? -PiQ30 : PiQ30;
        end else begin
          cin_r[k].x <= px;
          cin_r[k].y <= py;
          cin_r[k].z <= '0;
        end
      end
    end
  end

  cvec_t cout_w [4];
  for (genvar k = 0; k < 4; k++) begin : g_wheel
    swik_cordic u_cordic (.clk(clk), .en(en), .vin(cin_r[k]), .vout(cout_w[k]));
  end

  // post stage A: m = round(x * kinv / 2^30)
  logic [XyW-1:0]      m_r  [4];
  logic signed [16:0]  a_r  [4];
  logic                nz_a_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        logic [61:0] pr;
        logic signed [ZW-1:0] zr;
        pr = 62'(cout_w[k].x) * 62'(KinvQ30) + 62'd536870912;
        m_r[k]   <= XyW'(pr >> 30);
        zr = cout_w[k].z + ZW'(131072);
        a_r[k]   <= 17'(zr >>> 18);
        nz_a_r[k] <= cout_w[k].nz;
      end
    end
  end

  // post stage B: gain multiply, steer offset
  logic [43:0]        d_r  [4];
  logic signed [17:0] s_r  [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        d_r[k] <= nz_a_r[k] ? 44'(m_r[k]) * 44'(drive_gain_r) : '0;
        s_r[k] <= (nz_a_r[k] ? 18'(a_r[k]) : 18'sd0) + 18'(offset_r[k]);
      end
    end
  end

  // post stage C: round and saturate
  out_word_t od_r;
  logic [15:0]        dv [4];
  logic signed [15:0] sv [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [44:0] t;
      t = 45'(d_r[k]) + 45'd8388608;
      dv[k] = (t[44:24] > 21'd65535) ? 16'hFFFF : t[39:24];
      if (s_r[k] > 18'sd32767) sv[k] = 16'sh7FFF;
      else if (s_r[k] < -18'sd32768) sv[k] = 16'sh8000;
      else sv[k] = s_r[k][15:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      od_r.fl_drive <= dv[0]; od_r.fr_drive <= dv[1];
      od_r.bl_drive <= dv[2]; od_r.br_drive <= dv[3];
      od_r.fl_steer <= sv[0]; od_r.fr_steer <= sv[1];
      od_r.bl_steer <= sv[2]; od_r.br_steer <= sv[3];
    end
  end
  assign out_data = od_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved while held");

endmodule

@@ rtl/swik_cordic.sv @@
// ----------------------------------------------------------------------------
// swik_cordic: pipelined CORDIC vectoring for one wheel
// One micro-rotation per stage; stages advance together under a shared enable.
// ----------------------------------------------------------------------------
module swik_cordic
  import swik_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  cvec_t vin,
  output cvec_t vout
);

  cvec_t stg_r [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    cvec_t src;
    cvec_t nxt;
    if (i == 0) begin : g_first
      assign src = vin;
    end else begin : g_next
      assign src = stg_r[i-1];
    end
    always_comb begin
      logic signed [XyW-1:0] xs, ys;
      xs = src.x >>> i;
      ys = src.y >>> i;
      nxt = src;
      if (!src.y[XyW-1]) begin
        nxt.x = src.x + ys;
        nxt.y = src.y - xs;
        nxt.z = src.z + atan_q30(i);
      end else begin
        nxt.x = src.x - ys;
        nxt.y = src.y + xs;
        nxt.z = src.z - atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) stg_r[i] <= nxt;
    end
  end

  assign vout = stg_r[CordicSteps-1];

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for swerve_inverse_kinematics
// Drives chassis command words through valid/stall handshakes under several
// idle/stall patterns, predicts the per-wheel drive and steer words with a
// bit-exact CORDIC model and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top
  import swik_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = CordicSteps + 7;
  localparam int WatchLimit = 20000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_word_t in_data;
  out_word_t out_data;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  swerve_inverse_kinematics dut (.*);

  // predictor copy of the registers
  longint radius_q12, gain_int;
  longint steer_ofs[4];

  in_word_t cmd_q[$];
  out_word_t wheel_q[$];
  int send_idle_pct, recv_stall_pct;
  int failures, quiet_cycles;
  bit stim_done;

  localparam longint AtanQ30[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic void wheel_polar(longint x, longint y, int k,
                                      output logic [15:0] drv,
                                      output logic [15:0] ang);
    longint z, xs, ys, m, d, a;
    z = 0;
    if (x == 0 && y == 0) begin
      drv = '0;
      a = 0;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += AtanQ30[i];
        end else begin
          x -= ys; y += xs; z -= AtanQ30[i];
        end
      end
      m = rnd_shift(x * 652032874, 30);
      if (m < 0) m = 0;
      d = rnd_shift(m * gain_int, 24);
      if (d > 65535) d = 65535;
      if (d < 0) d = 0;
      drv = d[15:0];
      a = rnd_shift(z, 18);
    end
    a += steer_ofs[k];
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    ang = a[15:0];
  endfunction

  function automatic out_word_t predict_wheels(in_word_t c);
    out_word_t r;
    longint vx, vy, w;
    logic [15:0] d[4], s[4];
    vx = longint'(c.vel_x) * 4096;
    vy = longint'(c.vel_y) * 4096;
    w = rnd_shift(longint'(c.yaw_rate) * radius_q12 * 759250125, 30);
    wheel_polar(vx + w, vy + w, 0, d[0], s[0]);
    wheel_polar(vx + w, vy - w, 1, d[1], s[1]);
    wheel_polar(vx - w, vy + w, 2, d[2], s[2]);
    wheel_polar(vx - w, vy - w, 3, d[3], s[3]);
    r.fl_drive = d[0]; r.fr_drive = d[1]; r.bl_drive = d[2]; r.br_drive = d[3];
    r.fl_steer = s[0]; r.fr_steer = s[1]; r.bl_steer = s[2]; r.br_steer = s[3];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        wheel_q.push_back(predict_wheels(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1;
          in_data <= cmd_q.pop_front();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (wheel_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          failures++;
        end else begin
          out_word_t e;
          e = wheel_q.pop_front();
          if (e.fl_drive !== out_data.fl_drive) begin
            $error("fl_drive exp %0d got %0d", e.fl_drive, out_data.fl_drive); failures++;
          end
          if (e.fr_drive !== out_data.fr_drive) begin
            $error("fr_drive exp %0d got %0d", e.fr_drive, out_data.fr_drive); failures++;
          end
          if (e.bl_drive !== out_data.bl_drive) begin
            $error("bl_drive exp %0d got %0d", e.bl_drive, out_data.bl_drive); failures++;
          end
          if (e.br_drive !== out_data.br_drive) begin
            $error("br_drive exp %0d got %0d", e.br_drive, out_data.br_drive); failures++;
          end
          if (e.fl_steer !== out_data.fl_steer) begin
            $error("fl_steer exp %0d got %0d", e.fl_steer, out_data.fl_steer); failures++;
          end
          if (e.fr_steer !== out_data.fr_steer) begin
            $error("fr_steer exp %0d got %0d", e.fr_steer, out_data.fr_steer); failures++;
          end
          if (e.bl_steer !== out_data.bl_steer) begin
            $error("bl_steer exp %0d got %0d", e.bl_steer, out_data.bl_steer); failures++;
          end
          if (e.br_steer !== out_data.br_steer) begin
            $error("br_steer exp %0d got %0d", e.br_steer, out_data.br_steer); failures++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready) || stim_done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_TURN_RADIUS: radius_q12 = val[14:0];
      REG_DRIVE_GAIN:  gain_int = val[11:0];
      default:         steer_ofs[idx - 2] = longint'(signed'(val));
    endcase
  endtask

  task automatic drain_pipe();
    while (cmd_q.size() > 0 || in_valid || wheel_q.size() > 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_edge16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t mk_cmd(logic [15:0] x, logic [15:0] y,
                                      logic [15:0] r);
    in_word_t c;
    c.vel_x = x; c.vel_y = y; c.yaw_rate = r;
    return c;
  endfunction

  task automatic random_cmds(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        cmd_q.push_back(mk_cmd(rnd_edge16(), rnd_edge16(), 16'h0));
      else
        cmd_q.push_back(mk_cmd(rnd_edge16(), rnd_edge16(), rnd_edge16()));
    end
  endtask

  task automatic random_regs();
    write_reg(REG_TURN_RADIUS, 16'($urandom_range(32767)));
    write_reg(REG_DRIVE_GAIN, 16'($urandom_range(4095)));
    write_reg(REG_FL_OFFSET, rnd_edge16());
    write_reg(REG_FR_OFFSET, rnd_edge16());
    write_reg(REG_BL_OFFSET, rnd_edge16());
    write_reg(REG_BR_OFFSET, rnd_edge16());
  endtask

  initial begin
    logic [15:0] ext[3];
    ext = '{16'h8000, 16'h7fff, 16'h0000};
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    failures = 0;
    quiet_cycles = 0;
    stim_done = 0;
    radius_q12 = 983; gain_int = 500;
    steer_ofs = '{5001, -14080, 3036, 5077};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero vector, extremes, axis cases at reset settings
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        for (int c = 0; c < 2; c++)
          cmd_q.push_back(mk_cmd(ext[a], ext[b], c ? 16'h7fff : 16'h8000));
    cmd_q.push_back(mk_cmd(16'h0, 16'h0, 16'h0));
    cmd_q.push_back(mk_cmd(16'hf000, 16'h0, 16'h0));
    cmd_q.push_back(mk_cmd(16'hf000, 16'hffff, 16'h0));
    cmd_q.push_back(mk_cmd(16'h0, 16'h1000, 16'h0));
    cmd_q.push_back(mk_cmd(16'h0, 16'h0, 16'h1000));
    drain_pipe();

    // register extremes, unknown index ignored
    write_reg(REG_TURN_RADIUS, 16'h7fff);
    write_reg(REG_DRIVE_GAIN, 16'h0fff);
    write_reg(REG_FL_OFFSET, 16'h7fff);
    write_reg(REG_FR_OFFSET, 16'h8000);
    write_reg(REG_BL_OFFSET, 16'h0000);
    write_reg(REG_BR_OFFSET, 16'hffff);
    @(posedge clk);
    cfg_valid <= 1; cfg_index <= 3'd6; cfg_data <= 16'h1234;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= 3'd7;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    random_cmds(150);
    drain_pipe();
    write_reg(REG_TURN_RADIUS, 16'h0000);
    write_reg(REG_DRIVE_GAIN, 16'h0000);
    random_cmds(100);
    drain_pipe();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      random_regs();
      random_cmds(200);
      drain_pipe();
    end

    stim_done = 1;
    if (failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ files.f @@
rtl/swik_pkg.sv
rtl/swik_cordic.sv
rtl/swerve_inverse_kinematics.sv
tb/tb_top.sv
